>>> sv/scb_pkg.sv
// Shared command and status types for the sprite collision bitmap block.
package scb_pkg;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;     // capture the accepted input beat
    logic calc;        // form screen position, map address and qualifier
    logic rd_en;       // read the occupancy bit
    logic commit;      // update map and flag, load a pixel result
    logic clr_wr;      // write one map entry to zero and advance the sweep
    logic load_clear;  // load the result of a clear beat
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;  // sweep counter sits on the last map entry
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage

>>> sv/scb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 76800
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/scb_ctrl.sv
// Controller state machine sequencing pixel checks and map clearing.
module scb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             func_i,
  input  scb_pkg::status_t status_i,
  output scb_pkg::cmd_t    cmd_o,
  output logic             in_stall_o
);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_CALC     = 3'd2;
  localparam logic [2:0] S_READ     = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_CLR      = 3'd5;
  localparam logic [2:0] S_CLR_DONE = 3'd6;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = func_i ? S_CLR : S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_CLR_DONE;
        end
      end
      S_CLR_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_clear = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  // State register; reset starts the wiping sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/scb_datapath.sv
// Datapath: input capture, address forming, occupancy map, hit flag and result register.
module scb_datapath #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  scb_pkg::cmd_t      cmd_i,
  output scb_pkg::status_t   status_o,
  input  logic signed [9:0]  origin_x_i,
  input  logic signed [9:0]  origin_y_i,
  input  logic [8:0]         col_offset_i,
  input  logic [8:0]         row_offset_i,
  input  logic [7:0]         pixel_alpha_i,
  input  logic               last_pixel_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               hit_o,
  output logic               sprite_end_o,
  output logic               clear_done_o
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // Captured input beat
  logic [9:0]  origin_x_q, origin_y_q;
  logic [8:0]  col_offset_q, row_offset_q;
  logic        opaque_q, last_q;

  // Address stage
  logic [10:0]   px, py;
  logic          on_screen;
  logic [AW-1:0] addr_d, addr_q;
  logic          qual_q;

  // Map, flag and sweep
  logic          sprite_hit_q, sprite_hit_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          clr_last;
  logic [0:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [0:0]    wr_data;
  logic          hit_new;

  // Result register
  logic out_valid_q, out_valid_d;
  logic hit_q, sprite_end_q, clear_done_q;
  logic out_free;

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      origin_x_q   <= origin_x_i;
      origin_y_q   <= origin_y_i;
      col_offset_q <= col_offset_i;
      row_offset_q <= row_offset_i;
      opaque_q     <= (pixel_alpha_i != 8'd0);
      last_q       <= last_pixel_i;
    end
  end

  // Screen position, bounds check and map address
  assign px = {origin_x_q[9], origin_x_q} + {2'b00, col_offset_q};
  assign py = {origin_y_q[9], origin_y_q} + {2'b00, row_offset_q};
  assign on_screen = !px[10] && (px[9:0] < 10'(SCREEN_WIDTH))
                  && !py[10] && (py[9:0] < 10'(SCREEN_HEIGHT));
  assign addr_d = AW'(py[8:0]) * AW'(SCREEN_WIDTH) + AW'(px[8:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q <= addr_d;
      qual_q <= on_screen && opaque_q && !sprite_hit_q;
    end
  end

  // Map port: sweep writes zero, a free qualified pixel writes one
  assign hit_new = sprite_hit_q | (qual_q & rd_data[0]);
  assign wr_en   = cmd_i.clr_wr | (cmd_i.commit & qual_q & !rd_data[0]);
  assign wr_addr = cmd_i.clr_wr ? clr_cnt_q : addr_q;
  assign wr_data = cmd_i.clr_wr ? 1'b0 : 1'b1;

  scb_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  // Advance the sweep counter, wrap after the last entry
  assign clr_last = (clr_cnt_q == AW'(DEPTH - 1));
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clr_wr) begin
      clr_cnt_d = clr_last ? '0 : clr_cnt_q + AW'(1);
    end
  end

  // Sprite hit flag: drop at sprite end and on clear
  always_comb begin
    sprite_hit_d = sprite_hit_q;
    if (cmd_i.commit) begin
      sprite_hit_d = last_q ? 1'b0 : hit_new;
    end else if (cmd_i.load_clear) begin
      sprite_hit_d = 1'b0;
    end
  end

  // Result handshake
  assign out_free = !out_valid_q || !out_stall_i;
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.commit || cmd_i.load_clear) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      sprite_hit_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      clr_cnt_q    <= clr_cnt_d;
      sprite_hit_q <= sprite_hit_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q        <= hit_new;
      sprite_end_q <= last_q;
      clear_done_q <= 1'b0;
    end else if (cmd_i.load_clear) begin
      hit_q        <= 1'b0;
      sprite_end_q <= 1'b0;
      clear_done_q <= 1'b1;
    end
  end

  assign status_o.clr_last = clr_last;
  assign status_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign sprite_end_o = sprite_end_q;
  assign clear_done_o = clear_done_q;

endmodule

>>> sv/sprite_collision_bitmap.sv
// Top level of the sprite collision detector over a one-bit screen occupancy map.
//
// Input channel (in_valid_i / in_stall_o): one beat is a sprite pixel (func_i = 0)
// or a command to wipe the whole map (func_i = 1). Pixels of a sprite come in
// order, the last one marked by last_pixel_i.
// Output channel (out_valid_o / out_stall_i): one beat per input beat, carrying
// hit_o, sprite_end_o and clear_done_o. A result sits in an output register.
// Pixel beat: after acceptance the controller steps through CALC (address
// multiply), READ (registered map read) and CHECK (read-modify-write of the
// occupancy bit), then takes the next beat; CHECK loads the result.
// Clear beat: one map entry is wiped per cycle, over all SCREEN_WIDTH *
// SCREEN_HEIGHT entries (76800 by default), then the result is loaded.
// Reset: the same wiping pass over all SCREEN_WIDTH * SCREEN_HEIGHT entries
// runs, with in_stall_o high throughout; the hit flag starts clear.
// Receiver stall: the result holds in the output register; the next beat is
// still accepted and processed, and waits to commit until the register frees.
module sprite_collision_bitmap #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic signed [9:0] origin_x_i,
  input  logic signed [9:0] origin_y_i,
  input  logic [8:0]        col_offset_i,
  input  logic [8:0]        row_offset_i,
  input  logic [7:0]        pixel_alpha_i,
  input  logic              last_pixel_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              hit_o,
  output logic              sprite_end_o,
  output logic              clear_done_o
);

  scb_pkg::cmd_t    cmd;
  scb_pkg::status_t status;

  // Sequencer
  scb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Map, flag and result path
  scb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .col_offset_i  (col_offset_i),
    .row_offset_i  (row_offset_i),
    .pixel_alpha_i (pixel_alpha_i),
    .last_pixel_i  (last_pixel_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .hit_o         (hit_o),
    .sprite_end_o  (sprite_end_o),
    .clear_done_o  (clear_done_o)
  );

endmodule
